@@ design/bpsr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream package
// Shared widths, register codes, configuration and result types, 565 packing.
// ----------------------------------------------------------------------------
package bpsr_pkg;

  localparam int CfgAddrW     = 4;
  localparam int CfgDataW     = 32;
  localparam int DataW        = 8;
  localparam int PixW         = 16;
  localparam int IdxW         = 20;
  localparam int DimW         = 11;
  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 1024;

  typedef enum logic [1:0] {
    DEPTH_4BIT  = 2'd0,
    DEPTH_24BIT = 2'd1,
    DEPTH_32BIT = 2'd2
  } depth_e;

  typedef enum logic [1:0] {
    REG_DEPTH  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  localparam logic [1:0] DepthCodeSpare = 2'd3;

  // Frame geometry as seen by the datapath
  typedef struct packed {
    depth_e              mode;
    logic [DimW-1:0]     units;
    logic [1:0]          pad;
    logic [DimW-1:0]     height;
    logic [IdxW-1:0]     frame_base;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [IdxW-1:0] index;
    logic            frame_end;
  } result_t;

  function automatic logic [PixW-1:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    pack565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

@@ design/bpsr_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream configuration registers
// APB register file for depth, width and height, plus derived frame geometry.
// ----------------------------------------------------------------------------
module bpsr_cfg_regs #(
  parameter int MaxWidth  = bpsr_pkg::DefMaxWidth,
  parameter int MaxHeight = bpsr_pkg::DefMaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpsr_pkg::CfgAddrW-1:0] paddr,
  input  logic [bpsr_pkg::CfgDataW-1:0] pwdata,
  output logic [bpsr_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output bpsr_pkg::cfg_t                cfg_o,
  output logic                          restart_o,
  output logic [bpsr_pkg::IdxW-1:0]     restart_base_o
);
  import bpsr_pkg::*;

  depth_e              mode_q, mode_d;
  logic [DimW-1:0]     width_q, width_d;
  logic [DimW-1:0]     height_q, height_d;
  cfg_t                cfg_q, cfg_d;
  logic                wr_en;
  logic                hit;
  logic [DimW-1:0]     w_eff;
  logic [DimW-1:0]     h_eff;
  logic [DimW:0]       w_inc;
  logic [2*DimW-1:0]   base_prod;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    mode_d   = mode_q;
    width_d  = width_q;
    height_d = height_q;
    hit      = 1'b0;
    if (wr_en) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_DEPTH: begin
          hit    = 1'b1;
          mode_d = (pwdata[1:0] == DepthCodeSpare) ? DEPTH_32BIT : depth_e'(pwdata[1:0]);
        end
        REG_WIDTH: begin
          hit     = 1'b1;
          width_d = pwdata[DimW-1:0];
        end
        REG_HEIGHT: begin
          hit      = 1'b1;
          height_d = pwdata[DimW-1:0];
        end
        default: hit = 1'b0;
      endcase
    end
  end

  // Clamp to 1..max and derive the per-row geometry from the next values
  always_comb begin
    if (width_d == '0) begin
      w_eff = DimW'(1);
    end else if (32'(width_d) > MaxWidth) begin
      w_eff = DimW'(MaxWidth);
    end else begin
      w_eff = width_d;
    end
    if (height_d == '0) begin
      h_eff = DimW'(1);
    end else if (32'(height_d) > MaxHeight) begin
      h_eff = DimW'(MaxHeight);
    end else begin
      h_eff = height_d;
    end
    w_inc       = {1'b0, w_eff} + (DimW+1)'(1);
    cfg_d.mode  = mode_d;
    cfg_d.units = (mode_d == DEPTH_4BIT) ? w_inc[DimW:1] : w_eff;
    case (mode_d)
      DEPTH_4BIT:  cfg_d.pad = 2'b00 - cfg_d.units[1:0];
      DEPTH_24BIT: cfg_d.pad = w_eff[1:0];
      default:     cfg_d.pad = 2'b00;
    endcase
    cfg_d.height     = h_eff;
    base_prod        = (h_eff - DimW'(1)) * cfg_d.units;
    cfg_d.frame_base = base_prod[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= DEPTH_24BIT;
      width_q          <= DimW'(1);
      height_q         <= DimW'(1);
      cfg_q.mode       <= DEPTH_24BIT;
      cfg_q.units      <= DimW'(1);
      cfg_q.pad        <= 2'd1;
      cfg_q.height     <= DimW'(1);
      cfg_q.frame_base <= '0;
    end else begin
      mode_q   <= mode_d;
      width_q  <= width_d;
      height_q <= height_d;
      cfg_q    <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx_e'(paddr[3:2]))
      REG_DEPTH:  prdata = CfgDataW'(mode_q);
      REG_WIDTH:  prdata = CfgDataW'(width_q);
      REG_HEIGHT: prdata = CfgDataW'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o          = cfg_q;
  assign restart_o      = hit;
  assign restart_base_o = cfg_d.frame_base;

endmodule

@@ design/bpsr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream core
// Byte phase, colour holds, column/row/padding counters and 565 packing.
// ----------------------------------------------------------------------------
module bpsr_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpsr_pkg::cfg_t            cfg_i,
  input  logic                      restart_i,
  input  logic [bpsr_pkg::IdxW-1:0] restart_base_i,
  input  logic                      step_i,
  input  logic [bpsr_pkg::DataW-1:0] data_byte_i,
  output logic                      emit_o,
  output bpsr_pkg::result_t         res_o
);
  import bpsr_pkg::*;

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      blue_q, blue_d;
  logic [7:0]      green_q, green_d;
  logic [7:0]      red_q, red_d;
  logic [DimW-1:0] col_q, col_d;
  logic [1:0]      pad_q, pad_d;
  logic [DimW-1:0] row_q, row_d;
  logic [IdxW-1:0] base_q, base_d;
  logic [1:0]      emit_phase;
  logic            emit;
  logic            finish_row;
  logic            last_col;
  logic            last_row;
  logic [DimW:0]   col_inc;
  logic [DimW:0]   row_inc;

  assign col_inc  = {1'b0, col_q} + (DimW+1)'(1);
  assign row_inc  = {1'b0, row_q} + (DimW+1)'(1);
  assign last_col = col_inc >= {1'b0, cfg_i.units};
  assign last_row = row_inc >= {1'b0, cfg_i.height};

  always_comb begin
    phase_d         = phase_q;
    blue_d          = blue_q;
    green_d         = green_q;
    red_d           = red_q;
    col_d           = col_q;
    pad_d           = pad_q;
    row_d           = row_q;
    base_d          = base_q;
    emit            = 1'b0;
    finish_row      = 1'b0;
    emit_phase      = (cfg_i.mode == DEPTH_24BIT) ? 2'd2 : 2'd3;
    res_o.pixel     = {{(PixW-DataW){1'b0}}, data_byte_i};
    res_o.index     = base_q + IdxW'(col_q);
    res_o.frame_end = last_col && last_row;

    if (pad_q != 2'd0) begin
      // drop padding byte
      pad_d      = pad_q - 2'd1;
      finish_row = (pad_q == 2'd1);
    end else if (cfg_i.mode == DEPTH_4BIT) begin
      emit = 1'b1;
    end else if (phase_q < emit_phase) begin
      case (phase_q)
        2'd0:    blue_d  = data_byte_i;
        2'd1:    green_d = data_byte_i;
        default: red_d   = data_byte_i;
      endcase
      phase_d = phase_q + 2'd1;
    end else begin
      phase_d = 2'd0;
      emit    = 1'b1;
      if (cfg_i.mode == DEPTH_24BIT) begin
        red_d       = data_byte_i;
        res_o.pixel = pack565(data_byte_i, green_q, blue_q);
      end else begin
        res_o.pixel = pack565(red_q, green_q, blue_q);
      end
    end

    if (emit) begin
      if (last_col) begin
        col_d = '0;
        if (cfg_i.pad != 2'd0) begin
          pad_d = cfg_i.pad;
        end else begin
          finish_row = 1'b1;
        end
      end else begin
        col_d = col_inc[DimW-1:0];
      end
    end

    if (finish_row) begin
      if (last_row) begin
        row_d  = '0;
        base_d = cfg_i.frame_base;
      end else begin
        row_d  = row_inc[DimW-1:0];
        base_d = base_q - IdxW'(cfg_i.units);
      end
    end
  end

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      col_q   <= '0;
      pad_q   <= '0;
      row_q   <= '0;
      base_q  <= '0;
    end else if (restart_i) begin
      phase_q <= '0;
      col_q   <= '0;
      pad_q   <= '0;
      row_q   <= '0;
      base_q  <= restart_base_i;
    end else if (step_i) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      pad_q   <= pad_d;
      row_q   <= row_d;
      base_q  <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      blue_q  <= blue_d;
      green_q <= green_d;
      red_q   <= red_d;
    end
  end

`ifndef SYNTHESIS
  a_pad_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q != 2'd0 |-> phase_q == 2'd0)
    else $error("padding skipped in the middle of a pixel");

  a_4bit_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.mode == DEPTH_4BIT |-> phase_q == 2'd0)
    else $error("byte phase advanced in 4-bit mode");

  a_24bit_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.mode == DEPTH_24BIT |-> phase_q != 2'd3)
    else $error("byte phase past the red byte in 24-bit mode");
`endif

endmodule

@@ design/bmp_pixel_stream_to_rgb565_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream to RGB565 unit
// Converts the pixel area of an uncompressed BMP frame into indexed results.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the pixel data area of a frame, padding included, one byte per
//   transfer on the input channel (in_valid_i / in_stall_o / data_byte_i).
//   Results leave on the output channel (out_valid_o / out_stall_i) with
//   pixel_value_o, buffer_index_o (rows top-down) and frame_end_o.
//   The APB port sets depth, width and height; a write to any of these three
//   registers restarts the frame, so write only while no transfer is in flight.
// Timing:
//   One byte is accepted every cycle while in_stall_o is low. An accepted byte
//   is registered in the input register, and its result, if any, is
//   registered in the output register as the byte leaves the input register.
//   A 24-bit pixel takes three bytes, a 32-bit pixel four, a 4-bit byte one;
//   padding bytes and partial pixels give no result.
// Reset:
//   Clears both pipeline valid flags and the counters; depth returns to 24-bit,
//   width and height to one.
// Stall:
//   While the output is stalled with a result waiting, the input register
//   holds its byte and in_stall_o rises once that register is occupied.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_to_rgb565_unit #(
  parameter int MaxWidth  = bpsr_pkg::DefMaxWidth,
  parameter int MaxHeight = bpsr_pkg::DefMaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpsr_pkg::CfgAddrW-1:0] paddr,
  input  logic [bpsr_pkg::CfgDataW-1:0] pwdata,
  output logic [bpsr_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bpsr_pkg::DataW-1:0]    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpsr_pkg::PixW-1:0]     pixel_value_o,
  output logic [bpsr_pkg::IdxW-1:0]     buffer_index_o,
  output logic                          frame_end_o
);
  import bpsr_pkg::*;

  cfg_t            cfg;
  logic            restart;
  logic [IdxW-1:0] restart_base;
  logic            s1_valid_q, s1_valid_d;
  logic [DataW-1:0] s1_byte_q;
  logic            advance;
  logic            step;
  logic            emit;
  result_t         res;
  logic            out_valid_q, out_valid_d;
  result_t         out_q;

  bpsr_cfg_regs #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cfg_o          (cfg),
    .restart_o      (restart),
    .restart_base_o (restart_base)
  );

  bpsr_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .restart_i      (restart),
    .restart_base_i (restart_base),
    .step_i         (step),
    .data_byte_i    (s1_byte_q),
    .emit_o         (emit),
    .res_o          (res)
  );

  // Advance whenever the result register is free or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  assign s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;
  assign out_valid_d = advance ? (step && emit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= data_byte_i;
    end
    if (step && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_q.pixel;
  assign buffer_index_o = out_q.index;
  assign frame_end_o    = out_q.frame_end;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_byte_q))
    else $error("held input byte lost");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a byte in the input register");
`endif

endmodule

@@ verif/bmp_pixel_stream_to_rgb565_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream to RGB565 unit testbench
// Streams pixel-area bytes through several depth and geometry settings,
// mirrors the conversion locally and checks every result transfer in order.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_to_rgb565_unit_tb;
  import bpsr_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 1150;
  localparam int DrainCycles = 4;
  localparam int HoldCycles  = 80;
  localparam int DirSteps    = 32;

  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_BYTE,
    STEP_BYTE_KNOWN
  } step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    reg_idx_e            regsel;
    logic [CfgDataW-1:0] value;
    result_t             want;
  } dir_step_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall_o;
  logic [DataW-1:0]    data_byte;
  logic                out_valid_o;
  logic                out_stall;
  logic [PixW-1:0]     pixel_value_o;
  logic [IdxW-1:0]     buffer_index_o;
  logic                frame_end_o;

  // Local copy of the conversion state and registers
  depth_e          m_mode;
  logic [DimW-1:0] m_width;
  logic [DimW-1:0] m_height;
  logic [1:0]      m_phase;
  logic [7:0]      m_blue;
  logic [7:0]      m_green;
  logic [7:0]      m_red;
  logic [DimW-1:0] m_col;
  logic [1:0]      m_pad;
  logic [DimW-1:0] m_row;
  logic [IdxW-1:0] m_base;

  result_t     pending_pixels[$];
  int unsigned pixel_bytes;
  int unsigned err_cnt;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_arm;
  bit          hold_taken;
  int unsigned hold_left;

  dir_step_t dir_steps [DirSteps] = '{
    '{STEP_BYTE,       REG_DEPTH,  32'hFF, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'hFF, '0},
    '{STEP_BYTE_KNOWN, REG_DEPTH,  32'hFF, '{16'hFFFF, 20'd0, 1'b1}},
    '{STEP_BYTE,       REG_DEPTH,  32'h5C, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h00, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h00, '0},
    '{STEP_BYTE_KNOWN, REG_DEPTH,  32'h00, '{16'h0000, 20'd0, 1'b1}},
    '{STEP_BYTE,       REG_DEPTH,  32'h00, '0},
    '{STEP_CFG,        REG_DEPTH,  32'(DEPTH_4BIT), '0},
    '{STEP_CFG,        REG_WIDTH,  32'd3, '0},
    '{STEP_CFG,        REG_HEIGHT, 32'd2, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'hA5, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h5A, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h33, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'hCC, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h0F, '0},
    '{STEP_BYTE_KNOWN, REG_DEPTH,  32'hF0, '{16'h00F0, 20'd1, 1'b1}},
    '{STEP_BYTE,       REG_DEPTH,  32'h81, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h7E, '0},
    '{STEP_CFG,        REG_DEPTH,  32'(DepthCodeSpare), '0},
    '{STEP_CFG,        REG_WIDTH,  32'd0, '0},
    '{STEP_CFG,        REG_HEIGHT, 32'd2047, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'hF8, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'hFC, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h07, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'hAA, '0},
    '{STEP_CFG,        REG_WIDTH,  32'd2047, '0},
    '{STEP_CFG,        REG_HEIGHT, 32'd1024, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h01, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h02, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h04, '0},
    '{STEP_BYTE,       REG_DEPTH,  32'h80, '0}
  };

  bmp_pixel_stream_to_rgb565_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .pixel_value_o  (pixel_value_o),
    .buffer_index_o (buffer_index_o),
    .frame_end_o    (frame_end_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned geo_width();
    if (m_width == '0) return 1;
    if (m_width > DefMaxWidth) return DefMaxWidth;
    return m_width;
  endfunction

  function automatic int unsigned geo_height();
    if (m_height == '0) return 1;
    if (m_height > DefMaxHeight) return DefMaxHeight;
    return m_height;
  endfunction

  // Row length in destination units: bytes in 4-bit mode, pixels otherwise
  function automatic int unsigned geo_units();
    return (m_mode == DEPTH_4BIT) ? (geo_width() + 1) / 2 : geo_width();
  endfunction

  function automatic int unsigned geo_pad();
    int unsigned w;
    w = geo_width();
    case (m_mode)
      DEPTH_4BIT:  return ((4 * w + 31) / 32) * 4 - (w + 1) / 2;
      DEPTH_24BIT: return w % 4;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned frame_bytes();
    int unsigned row_len;
    case (m_mode)
      DEPTH_4BIT:  row_len = geo_units();
      DEPTH_24BIT: row_len = geo_units() * 3;
      default:     row_len = geo_units() * 4;
    endcase
    return (row_len + geo_pad()) * geo_height();
  endfunction

  task automatic restart_frame();
    m_phase = '0;
    m_col   = '0;
    m_pad   = '0;
    m_row   = '0;
    m_base  = IdxW'((geo_height() - 1) * geo_units());
  endtask

  task automatic close_row();
    m_row = m_row + 1'b1;
    if (m_row >= geo_height()) begin
      m_row  = '0;
      m_base = IdxW'((geo_height() - 1) * geo_units());
    end else begin
      m_base = m_base - IdxW'(geo_units());
    end
  endtask

  task automatic reset_model();
    m_mode   = DEPTH_24BIT;
    m_width  = 1;
    m_height = 1;
    m_blue   = '0;
    m_green  = '0;
    m_red    = '0;
    restart_frame();
  endtask

  task automatic set_register(input reg_idx_e r, input logic [CfgDataW-1:0] v);
    case (r)
      REG_DEPTH:  m_mode = (v[1:0] == DepthCodeSpare) ? DEPTH_32BIT : depth_e'(v[1:0]);
      REG_WIDTH:  m_width = v[DimW-1:0];
      default:    m_height = v[DimW-1:0];
    endcase
    restart_frame();
  endtask

  // Work out the result, if any, that one accepted byte produces
  task automatic convert_byte(input logic [7:0] b, output bit got, output result_t res);
    int unsigned     emit_at;
    logic [PixW-1:0] pix;
    bit              last_col;
    got = 1'b0;
    res = '0;
    pixel_bytes++;
    if (m_pad != '0) begin
      m_pad = m_pad - 1'b1;
      if (m_pad == '0) close_row();
      return;
    end
    if (m_mode == DEPTH_4BIT) begin
      pix = {8'h00, b};
    end else begin
      emit_at = (m_mode == DEPTH_24BIT) ? 2 : 3;
      if (m_phase < emit_at) begin
        case (m_phase)
          2'd0:    m_blue = b;
          2'd1:    m_green = b;
          default: m_red = b;
        endcase
        m_phase = m_phase + 1'b1;
        return;
      end
      if (m_mode == DEPTH_24BIT) m_red = b;
      m_phase = '0;
      pix = {m_red[7:3], m_green[7:2], m_blue[7:3]};
    end
    last_col      = (m_col + 1 >= geo_units());
    res.pixel     = pix;
    res.index     = m_base + IdxW'(m_col);
    res.frame_end = last_col && (m_row + 1 >= geo_height());
    got = 1'b1;
    if (last_col) begin
      m_col = '0;
      if (geo_pad() != 0) m_pad = 2'(geo_pad());
      else close_row();
    end else begin
      m_col = m_col + 1'b1;
    end
  endtask

  task automatic apb_write(input reg_idx_e r, input logic [CfgDataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    set_register(r, v);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit known, input result_t want);
    bit      got;
    result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk_i); while (in_stall_o);
    convert_byte(b, got, res);
    if (known) pending_pixels.push_back(want);
    else if (got) pending_pixels.push_back(res);
  endtask

  // Let every result out, then allow for a partial pixel or padding in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : pixel_monitor
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected result: pixel_value %h buffer_index %0d frame_end %b",
                 pixel_value_o, buffer_index_o, frame_end_o);
          err_cnt++;
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_value_o !== want.pixel) begin
            $error("pixel_value: expected %h, got %h", want.pixel, pixel_value_o);
            err_cnt++;
          end
          if (buffer_index_o !== want.index) begin
            $error("buffer_index: expected %0d, got %0d", want.index, buffer_index_o);
            err_cnt++;
          end
          if (frame_end_o !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, frame_end_o);
            err_cnt++;
          end
        end
      end
      if (hold_arm && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldCycles;
      end
      // Hold the output off for a long stretch so that the input backs up
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("bmp_pixel_stream_to_rgb565_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned n_bytes;
    int unsigned pick;
    logic [CfgDataW-1:0] v;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    data_byte     = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_arm      = 1'b0;
    hold_taken    = 1'b0;
    hold_left     = 0;
    err_cnt       = 0;
    cycles        = 0;
    pixel_bytes   = 0;
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_steps[k]) begin
      if (dir_steps[k].kind == STEP_CFG) begin
        drain();
        apb_write(dir_steps[k].regsel, dir_steps[k].value);
      end else begin
        push_byte(dir_steps[k].value[7:0], dir_steps[k].kind == STEP_BYTE_KNOWN,
                  dir_steps[k].want);
      end
    end
    drain();

    pixel_bytes = 0;
    phase_no    = 0;
    while (pixel_bytes < RandomBytes) begin
      case (phase_no % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      if (phase_no == 0) begin
        // Unpadded 4-bit frame: every byte gives a result, so the pipe fills
        apb_write(REG_DEPTH, 32'(DEPTH_4BIT));
        apb_write(REG_WIDTH, 32'd8);
        apb_write(REG_HEIGHT, 32'd16);
        n_bytes  = frame_bytes();
        hold_arm = 1'b1;
      end else begin
        if ($urandom_range(0, 3) != 0) apb_write(REG_DEPTH, 32'($urandom_range(0, 3)));
        if ($urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, 15);
          if (pick == 0) v = $urandom_range(0, 2047);
          else if (pick == 1) v = ($urandom_range(0, 1) != 0) ? 32'd1024 : 32'd2047;
          else if (pick == 2) v = 32'd0;
          else v = $urandom_range(1, 9);
          apb_write(REG_WIDTH, v);
        end
        if ($urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, 15);
          if (pick == 0) v = $urandom_range(0, 2047);
          else if (pick == 1) v = ($urandom_range(0, 1) != 0) ? 32'd1024 : 32'd2047;
          else if (pick == 2) v = 32'd0;
          else v = $urandom_range(1, 4);
          apb_write(REG_HEIGHT, v);
        end
        // Whole frames where they are short, a leading slice of large ones, at times a short run
        if (frame_bytes() <= 240) n_bytes = frame_bytes() * $urandom_range(1, 3);
        else n_bytes = $urandom_range(40, 240);
        if ($urandom_range(0, 7) == 0) n_bytes = $urandom_range(1, 30);
      end
      // Stop at the byte budget
      if (n_bytes > RandomBytes - pixel_bytes) n_bytes = RandomBytes - pixel_bytes;
      repeat (n_bytes) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      drain();
      phase_no++;
    end

    if (pending_pixels.size() != 0) begin
      $error("%0d results never arrived", pending_pixels.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("bmp_pixel_stream_to_rgb565_unit: match");
    end else begin
      $display("bmp_pixel_stream_to_rgb565_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/bpsr_pkg.sv
design/bpsr_cfg_regs.sv
design/bpsr_core.sv
design/bmp_pixel_stream_to_rgb565_unit.sv
verif/bmp_pixel_stream_to_rgb565_unit_tb.sv
